// ===== src/slxfr_pkg.sv =====
// Shared constants, types and command/status bundles for the frame receiver.
package slxfr_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int CFG_IDX_W   = 1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 7'd64;
	localparam logic [LEN_W-1:0]  MAX_LEN_CAP    = LEN_W'(MAX_PAYLOAD);

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 1'b1;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN,
		ST_DATA,
		ST_SUM,
		ST_REPLAY
	} state_t;

	typedef struct packed {
		logic take_len;
		logic store_byte;
		logic start_replay;
		logic issue_rd;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_start;
		logic len_ok;
		logic data_done;
		logic sum_ok;
		logic can_issue;
		logic rd_last;
	} dp_stat_t;

endpackage

// ===== src/sof_length_xor_frame_receiver_unit.sv =====
// Top level of the start-byte / length / XOR-checksum frame receiver.
// Input: one received byte per cycle while framing; no input during payload replay.
// Replay starts once the checksum beat is accepted; store reads pass stage s1, then s2.
// Replay: one beat per cycle without back-pressure, set by the single read port of
// the 64-entry payload store; input is held off until the frame's last byte is read.
// Reset: asynchronous, clears control state and config (start 0xA5, max length 64);
// the payload store is not cleared.
module sof_length_xor_frame_receiver_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slxfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slxfr_pkg::BYTE_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [slxfr_pkg::BYTE_W-1:0]        rx_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [slxfr_pkg::BYTE_W-1:0]        payload_byte,
	output logic [slxfr_pkg::ADDR_W-1:0]        payload_index,
	output logic [slxfr_pkg::LEN_W-1:0]         frame_length,
	output logic                                last
);

	slxfr_pkg::ctrl_cmd_t cmd;
	slxfr_pkg::dp_stat_t  stat;

	slxfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	slxfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_length (frame_length),
		.last         (last)
	);

	// no store read while a byte may be written
	a_no_rd_while_rx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_rd |-> !in_ready)
		else $error("store read issued while input is open");

	// last beat sits at the end of the frame
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |->
			(({1'b0, payload_index} + 7'd1) == frame_length))
		else $error("last beat not at final payload position");

	// replayed frame length stays in range
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_length != '0) && (frame_length <= slxfr_pkg::MAX_LEN_CAP))
		else $error("replayed frame length out of range");

	// index stays below the frame length
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, payload_index} < frame_length))
		else $error("payload index beyond frame length");

endmodule

// ===== src/slxfr_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
module slxfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/slxfr_ctrl.sv =====
// Frame receiver controller: hunt, length, data, checksum and replay sequencing.
module slxfr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  slxfr_pkg::dp_stat_t   stat,
	output slxfr_pkg::ctrl_cmd_t  cmd
);

	slxfr_pkg::state_t state_q, state_d;
	logic              in_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slxfr_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q != slxfr_pkg::ST_REPLAY);
		in_beat  = in_valid && in_ready;
		case (state_q)
			slxfr_pkg::ST_HUNT: begin
				if (in_beat && stat.is_start) begin
					state_d = slxfr_pkg::ST_LEN;
				end
			end
			slxfr_pkg::ST_LEN: begin
				if (in_beat) begin
					if (stat.len_ok) begin
						cmd.take_len = 1'b1;
						state_d      = slxfr_pkg::ST_DATA;
					end else begin
						state_d = slxfr_pkg::ST_HUNT;
					end
				end
			end
			slxfr_pkg::ST_DATA: begin
				if (in_beat) begin
					cmd.store_byte = 1'b1;
					if (stat.data_done) begin
						state_d = slxfr_pkg::ST_SUM;
					end
				end
			end
			slxfr_pkg::ST_SUM: begin
				if (in_beat) begin
					if (stat.sum_ok) begin
						cmd.start_replay = 1'b1;
						state_d          = slxfr_pkg::ST_REPLAY;
					end else begin
						state_d = slxfr_pkg::ST_HUNT;
					end
				end
			end
			slxfr_pkg::ST_REPLAY: begin
				cmd.issue_rd = stat.can_issue;
				if (stat.can_issue && stat.rd_last) begin
					state_d = slxfr_pkg::ST_HUNT;
				end
			end
			default: begin
				state_d = slxfr_pkg::ST_HUNT;
			end
		endcase
	end

endmodule

// ===== src/slxfr_dp.sv =====
// Frame receiver datapath: config registers, length/checksum tracking, store and replay pipe.
module slxfr_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [slxfr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [slxfr_pkg::BYTE_W-1:0]           cfg_wdata,
	input  logic [slxfr_pkg::BYTE_W-1:0]           rx_byte,
	input  slxfr_pkg::ctrl_cmd_t                   cmd,
	output slxfr_pkg::dp_stat_t                    stat,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [slxfr_pkg::BYTE_W-1:0]           payload_byte,
	output logic [slxfr_pkg::ADDR_W-1:0]           payload_index,
	output logic [slxfr_pkg::LEN_W-1:0]            frame_length,
	output logic                                   last
);

	logic [slxfr_pkg::BYTE_W-1:0] start_byte_q;
	logic [slxfr_pkg::LEN_W-1:0]  max_len_q;
	logic [slxfr_pkg::LEN_W-1:0]  limit;
	logic [slxfr_pkg::LEN_W-1:0]  exp_len_q;
	logic [slxfr_pkg::LEN_W-1:0]  byte_cnt_q;
	logic [slxfr_pkg::LEN_W-1:0]  byte_cnt_nxt;
	logic [slxfr_pkg::BYTE_W-1:0] xor_q;
	logic [slxfr_pkg::LEN_W-1:0]  rd_idx_q;
	logic [slxfr_pkg::LEN_W-1:0]  rd_idx_nxt;

	logic                         valid_s1;
	logic [slxfr_pkg::ADDR_W-1:0] idx_s1;
	logic [slxfr_pkg::LEN_W-1:0]  len_s1;
	logic                         last_s1;
	logic [slxfr_pkg::BYTE_W-1:0] byte_s1;

	logic                         valid_s2;
	logic [slxfr_pkg::BYTE_W-1:0] byte_s2;
	logic [slxfr_pkg::ADDR_W-1:0] idx_s2;
	logic [slxfr_pkg::LEN_W-1:0]  len_s2;
	logic                         last_s2;
	logic                         adv_s2;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= slxfr_pkg::START_BYTE_RST;
			max_len_q    <= slxfr_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slxfr_pkg::REG_START_BYTE: start_byte_q <= cfg_wdata;
				slxfr_pkg::REG_MAX_LEN:    max_len_q    <= cfg_wdata[slxfr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign limit = (max_len_q > slxfr_pkg::MAX_LEN_CAP) ? slxfr_pkg::MAX_LEN_CAP : max_len_q;

	assign byte_cnt_nxt = byte_cnt_q + slxfr_pkg::LEN_W'(1);
	assign rd_idx_nxt   = rd_idx_q + slxfr_pkg::LEN_W'(1);
	assign adv_s2       = !valid_s2 || out_ready;

	always_comb begin
		stat           = '0;
		stat.is_start  = (rx_byte == start_byte_q);
		stat.len_ok    = (rx_byte != '0) && (rx_byte <= {1'b0, limit});
		stat.data_done = (byte_cnt_nxt >= exp_len_q);
		stat.sum_ok    = (rx_byte == xor_q);
		stat.can_issue = !valid_s1 || adv_s2;
		stat.rd_last   = (rd_idx_nxt == exp_len_q);
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q  <= '0;
			byte_cnt_q <= '0;
			xor_q      <= '0;
			rd_idx_q   <= '0;
		end else begin
			if (cmd.take_len) begin
				exp_len_q  <= rx_byte[slxfr_pkg::LEN_W-1:0];
				byte_cnt_q <= '0;
				xor_q      <= rx_byte;
			end else if (cmd.store_byte) begin
				byte_cnt_q <= byte_cnt_nxt;
				xor_q      <= xor_q ^ rx_byte;
			end
			if (cmd.start_replay) begin
				rd_idx_q <= '0;
			end else if (cmd.issue_rd) begin
				rd_idx_q <= rd_idx_nxt;
			end
		end
	end

	slxfr_ram #(
		.WIDTH(slxfr_pkg::BYTE_W),
		.DEPTH(slxfr_pkg::MAX_PAYLOAD)
	) u_store (
		.clk  (clk),
		.we   (cmd.store_byte),
		.waddr(byte_cnt_q[slxfr_pkg::ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.issue_rd),
		.raddr(rd_idx_q[slxfr_pkg::ADDR_W-1:0]),
		.rdata(byte_s1)
	);

	// replay pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.issue_rd) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// replay pipe payload
	always_ff @(posedge clk) begin
		if (cmd.issue_rd) begin
			idx_s1  <= rd_idx_q[slxfr_pkg::ADDR_W-1:0];
			len_s1  <= exp_len_q;
			last_s1 <= stat.rd_last;
		end
		if (adv_s2 && valid_s1) begin
			byte_s2 <= byte_s1;
			idx_s2  <= idx_s1;
			len_s2  <= len_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_byte  = byte_s2;
	assign payload_index = idx_s2;
	assign frame_length  = len_s2;
	assign last          = last_s2;

endmodule

// ===== dv/tb_sof_length_xor_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the frame receiver: framed byte traffic checked beat by beat against a predictor.
module tb_sof_length_xor_frame_receiver_unit;
	import slxfr_pkg::*;

	typedef enum logic [1:0] {HUNT_SOF, READ_LEN, READ_DATA, READ_SUM} rx_phase_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_t;
	typedef enum logic [1:0] {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_LEN, FRAME_NOISE} frame_kind_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic [ADDR_W-1:0] index;
		logic [LEN_W-1:0]  length;
		logic              last;
	} payload_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_START_BYTE;
	logic [BYTE_W-1:0]    cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    payload_byte;
	logic [ADDR_W-1:0]    payload_index;
	logic [LEN_W-1:0]     frame_length;
	logic                 last;

	// predictor state
	logic [BYTE_W-1:0] start_byte_q = START_BYTE_RST;
	logic [LEN_W-1:0]  max_len_q = MAX_LEN_RST;
	rx_phase_t         rx_phase = HUNT_SOF;
	logic [LEN_W-1:0]  want_len = '0;
	logic [LEN_W-1:0]  byte_cnt = '0;
	logic [BYTE_W-1:0] xor_acc = '0;
	logic [BYTE_W-1:0] frame_store [MAX_PAYLOAD];

	payload_beat_t     expected_beats [$];
	logic [BYTE_W-1:0] rx_pending [$];

	int          errors = 0;
	int          bytes_queued = 0;
	int          bytes_accepted = 0;
	int          frames_verified = 0;
	int          beats_checked = 0;
	logic        in_fire = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          mode_left = 0;
	logic [15:0] stall_pattern = 16'b1101_1110_0111_0110;

	sof_length_xor_frame_receiver_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_length (frame_length),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int store_limit();
		return (max_len_q > MAX_LEN_CAP) ? MAX_PAYLOAD : int'(max_len_q);
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (errors < 50)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
		errors++;
	endtask

	task automatic accept_rx_byte(input logic [BYTE_W-1:0] b);
		payload_beat_t beat;
		case (rx_phase)
		HUNT_SOF: begin
			if (b == start_byte_q)
				rx_phase = READ_LEN;
		end
		READ_LEN: begin
			if (b == '0 || int'(b) > store_limit()) begin
				rx_phase = HUNT_SOF;
			end else begin
				want_len = b[LEN_W-1:0];
				byte_cnt = '0;
				xor_acc  = b;
				rx_phase = READ_DATA;
			end
		end
		READ_DATA: begin
			if (byte_cnt < MAX_PAYLOAD)
				frame_store[byte_cnt] = b;
			xor_acc  = xor_acc ^ b;
			byte_cnt = byte_cnt + LEN_W'(1);
			if (byte_cnt >= want_len)
				rx_phase = READ_SUM;
		end
		default: begin
			rx_phase = HUNT_SOF;
			if (b == xor_acc) begin
				frames_verified++;
				for (int i = 0; i < want_len && i < MAX_PAYLOAD; i++) begin
					beat.data   = frame_store[i];
					beat.index  = i[ADDR_W-1:0];
					beat.length = want_len;
					beat.last   = (i + 1 == want_len);
					expected_beats.push_back(beat);
				end
			end
		end
		endcase
	endtask

	task automatic check_payload_beat();
		payload_beat_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("unexpected beat", payload_byte, 0);
			return;
		end
		want = expected_beats.pop_front();
		if (payload_byte !== want.data)
			report_mismatch("payload_byte", payload_byte, want.data);
		if (payload_index !== want.index)
			report_mismatch("payload_index", payload_index, want.index);
		if (frame_length !== want.length)
			report_mismatch("frame_length", frame_length, want.length);
		if (last !== want.last)
			report_mismatch("last", last, want.last);
		beats_checked++;
	endtask

	// monitor: config, input beats and output beats at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
				REG_START_BYTE: start_byte_q = cfg_wdata;
				REG_MAX_LEN:    max_len_q = cfg_wdata[LEN_W-1:0];
				default: ;
				endcase
			end
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				accept_rx_byte(rx_byte);
				bytes_accepted++;
			end
			if (out_valid && out_ready)
				check_payload_beat();
		end
	end

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin
		logic              nxt_valid;
		logic [BYTE_W-1:0] nxt_byte;
		nxt_valid = in_valid;
		nxt_byte  = rx_byte;
		if (in_valid && in_fire)
			nxt_valid = 1'b0;
		if (!nxt_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (rx_pending.size() > 0) begin
				nxt_valid = 1'b1;
				nxt_byte  = rx_pending.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_valid <= nxt_valid;
		rx_byte  <= nxt_byte;
	end

	// receiver: switch between always ready, a rotating stall pattern and random stalls
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			mode_left  = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		case (ready_mode)
		READY_ALWAYS: out_ready <= 1'b1;
		READY_PATTERN: begin
			out_ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
		default: out_ready <= ($urandom_range(0, 2) != 0);
		endcase
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		rx_pending.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_frame(input frame_kind_t kind, input int len);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int                lim;
		lim = store_limit();
		case (kind)
		FRAME_NOISE: begin
			repeat (len) queue_byte(BYTE_W'($urandom_range(0, 255)));
		end
		FRAME_BAD_LEN: begin
			queue_byte(start_byte_q);
			if ($urandom_range(0, 1) == 0)
				queue_byte('0);
			else
				queue_byte(BYTE_W'($urandom_range(lim + 1, 255)));
		end
		default: begin
			queue_byte(start_byte_q);
			queue_byte(BYTE_W'(len));
			sum = BYTE_W'(len);
			repeat (len) begin
				b = BYTE_W'($urandom_range(0, 255));
				queue_byte(b);
				sum = sum ^ b;
			end
			if (kind == FRAME_BAD_SUM)
				sum = sum ^ BYTE_W'(1 << $urandom_range(0, BYTE_W - 1));
			queue_byte(sum);
		end
		endcase
	endtask

	task automatic push_random_frames(input int count);
		int          target;
		int          lim;
		int          len;
		int          pick;
		frame_kind_t kind;
		target = bytes_queued + count;
		while (bytes_queued < target) begin
			lim  = store_limit();
			pick = $urandom_range(0, 7);
			if (lim == 0)
				len = $urandom_range(1, 4);
			else if (pick == 0)
				len = lim;
			else if (pick == 1)
				len = $urandom_range(1, lim);
			else
				len = $urandom_range(1, (lim < 6) ? lim : 6);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				kind = FRAME_GOOD;
			end else if (pick == 7) begin
				kind = FRAME_BAD_SUM;
			end else if (pick == 8) begin
				kind = FRAME_BAD_LEN;
			end else begin
				kind = FRAME_NOISE;
				len  = $urandom_range(1, 4);
			end
			push_frame(kind, len);
		end
	endtask

	task automatic wait_idle();
		while (rx_pending.size() != 0 || in_valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [BYTE_W-1:0] opening [21];
		opening = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'hA5, 8'hA5, 8'hA5, 8'h01, 8'hFF, 8'hFE,
			8'hA5, 8'h02, 8'h00, 8'hA5, 8'hA7, 8'hA5, 8'h01, 8'h12, 8'h00, 8'hA5, 8'h41};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// noise, zero length, oversize length, good frames, start byte as data, bad checksum
		foreach (opening[i])
			queue_byte(opening[i]);
		wait_idle();

		write_reg(REG_START_BYTE, 8'h00);
		write_reg(REG_MAX_LEN, 8'd1);
		push_random_frames(60);
		wait_idle();

		write_reg(REG_START_BYTE, 8'hFF);
		write_reg(REG_MAX_LEN, 8'd127);
		push_frame(FRAME_GOOD, MAX_PAYLOAD);
		push_frame(FRAME_BAD_LEN, 0);
		push_random_frames(80);
		wait_idle();

		write_reg(REG_START_BYTE, BYTE_W'($urandom_range(0, 255)));
		write_reg(REG_MAX_LEN, 8'd0);
		push_random_frames(30);
		wait_idle();

		write_reg(REG_START_BYTE, BYTE_W'($urandom_range(0, 255)));
		write_reg(REG_MAX_LEN, 8'h80 | BYTE_W'($urandom_range(1, MAX_PAYLOAD)));
		push_random_frames(60);
		wait_idle();

		write_reg(REG_START_BYTE, START_BYTE_RST);
		write_reg(REG_MAX_LEN, BYTE_W'(MAX_LEN_RST));
		push_frame(FRAME_GOOD, MAX_PAYLOAD);
		push_random_frames(60);
		wait_idle();
		push_random_frames(30);
		wait_idle();

		$display("sent %0d bytes over start bytes 0xA5/0x00/0xFF/random and limits 64/1/127/0/random",
			bytes_accepted);
		$display("%0d frames passed the checksum, %0d payload beats compared",
			frames_verified, beats_checked);
		if (errors == 0)
			$display("tb_sof_length_xor_frame_receiver_unit passed");
		else
			$display("tb_sof_length_xor_frame_receiver_unit failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d beats still expected", expected_beats.size());
		$display("tb_sof_length_xor_frame_receiver_unit failed");
		$finish;
	end

endmodule
